/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the bloom block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define IBS_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`define IBS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");
`define IBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define IBS_ASSERT_NEVER(lbl, expr)
`define IBS_ASSERT_IMPLY(lbl, ante, cons)
`define IBS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/ibs_pkg.sv */
// Types, constants and the reciprocal distance table of the bloom block.
`timescale 1ns / 1ps
package ibs_pkg;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_RADIUS  = 8;
  localparam int RCP_DEPTH   = 2 * MAX_RADIUS * MAX_RADIUS + 1;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_INTENSITY = 3'd3;
  localparam logic [2:0] REG_RADIUS    = 3'd4;

  typedef logic [RCP_DEPTH-1:0][15:0] rcp_rom_t;

  typedef struct packed {
    logic        issue;
    logic        valid;
    logic        last;
    logic [15:0] addr;
    logic [7:0]  d2;
  } ofs_t;

  // Nearest integer to 32768/sqrt(d): largest n with (2n-1)^2*d <= 2^32.
  function automatic rcp_rom_t rcp_table();
    rcp_rom_t    t;
    logic [63:0] n;
    logic [63:0] c;
    logic [63:0] q;
    t = '0;
    for (int d = 1; d < RCP_DEPTH; d++) begin
      n = '0;
      for (int b = 15; b >= 0; b--) begin
        c = n | (64'd1 << b);
        q = (2 * c - 64'd1) * (2 * c - 64'd1) * 64'(d);
        if (q <= (64'd1 << 32)) begin
          n = c;
        end
      end
      t[d] = n[15:0];
    end
    return t;
  endfunction

  localparam rcp_rom_t RCP_ROM = rcp_table();
endpackage

/* hdl/ibs_in_if.sv */
// Input channel of the bloom block.
`timescale 1ns / 1ps
interface ibs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] column;
  logic [7:0] row;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, action, column, row, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, action, column, row, red_in, green_in, blue_in,
                output ready);
endinterface

/* hdl/ibs_out_if.sv */
// Result channel of the bloom block.
`timescale 1ns / 1ps
interface ibs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* hdl/image_bloom_scatter.sv */
// Top level of the bloom engine: frame store, glow store and scatter pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// After reset, and after every clear item, the glow store is cleared one entry
// a cycle, all 65536 entries, during which no item is taken. A write item of a
// bright pixel inside the image, with a nonzero radius, walks (2*radius)^2
// kernel steps one at a time through the single read-modify-write port of the
// glow store. A read item waits until the output register is free to take its result.
module image_bloom_scatter
  import ibs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  ibs_in_if.sink      in_ch,
  ibs_out_if.source   out_ch
);
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] clr_cnt_r;
  logic [8:0]  width_r, height_r;
  logic [9:0]  thresh_r;
  logic [11:0] intens_r;
  logic [3:0]  radius_r;

  logic [23:0] frame_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [23:0] glow_mem [0:MAX_WIDTH*MAX_HEIGHT-1];
  logic [23:0] frame_q_r, glow_q_r;

  logic [8:0]  w_eff, h_eff;
  logic [3:0]  r_eff;
  logic        accept, in_image, bright, start;
  logic [15:0] in_addr;
  logic [9:0]  ch_sum;
  ofs_t        ofs;

  logic [2:0][19:0] p_r;
  logic             s1_valid_r, s1_center_r;
  logic [15:0]      s1_addr_r;
  logic [2:0][12:0] s1_g_r;
  logic [2:0][12:0] g_nxt;
  logic [23:0]      glow_wdata;
  logic             rd_inside_r;
  logic [23:0]      rd_data;
  logic             out_valid_r;
  logic [23:0]      out_data_r;
  logic             out_load;
  logic [7:0]       s1_rr;
  logic [13:0]      sum;

  assign w_eff   = (width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : width_r;
  assign h_eff   = (height_r > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : height_r;
  assign r_eff   = (radius_r > 4'(MAX_RADIUS)) ? 4'(MAX_RADIUS) : radius_r;
  assign in_ch.ready = state_r == ST_IDLE;
  assign accept  = in_ch.valid && in_ch.ready;
  assign in_image = ({1'b0, in_ch.column} < w_eff) && ({1'b0, in_ch.row} < h_eff);
  assign in_addr = {in_ch.row, in_ch.column};
  assign ch_sum  = 10'(in_ch.red_in) + 10'(in_ch.green_in) + 10'(in_ch.blue_in);
  assign bright  = ch_sum > thresh_r;
  assign start   = accept && in_ch.action == ACT_WRITE && in_image && bright
                   && r_eff != 4'd0;

  ibs_offset_gen u_ofs (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .col    (in_ch.column),
    .row    (in_ch.row),
    .radius (r_eff),
    .width  (w_eff),
    .height (h_eff),
    .ofs    (ofs)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      thresh_r <= 10'd383;
      intens_r <= 12'd256;
      radius_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:     width_r  <= cfg_wdata[8:0];
        REG_HEIGHT:    height_r <= cfg_wdata[8:0];
        REG_THRESHOLD: thresh_r <= cfg_wdata[9:0];
        REG_INTENSITY: intens_r <= cfg_wdata[11:0];
        REG_RADIUS:    radius_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_CLR: begin
        if (clr_cnt_r == 16'hFFFF) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_ch.action)
            ACT_WRITE: if (start) state_nxt = ST_SCAT;
            ACT_READ:  state_nxt = ST_READ;
            ACT_CLEAR: state_nxt = ST_CLR;
            default: ;
          endcase
        end
      end
      ST_SCAT: begin
        if (ofs.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      ST_READ: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_cnt_r <= clr_cnt_r + 16'd1;
      end else begin
        clr_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.action == ACT_WRITE && in_image) begin
      frame_mem[in_addr] <= {in_ch.blue_in, in_ch.green_in, in_ch.red_in};
    end
    if (accept && in_ch.action == ACT_READ) begin
      frame_q_r <= frame_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) begin
      glow_mem[clr_cnt_r] <= '0;
    end else if (s1_valid_r) begin
      glow_mem[s1_addr_r] <= glow_wdata;
    end
    if (ofs.valid) begin
      glow_q_r <= glow_mem[ofs.addr];
    end else if (accept && in_ch.action == ACT_READ) begin
      glow_q_r <= glow_mem[in_addr];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      g_nxt[k] = 13'((36'(p_r[k]) * 36'(RCP_ROM[ofs.d2])) >> 23);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r[0] <= 20'(in_ch.red_in) * 20'(intens_r);
      p_r[1] <= 20'(in_ch.green_in) * 20'(intens_r);
      p_r[2] <= 20'(in_ch.blue_in) * 20'(intens_r);
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= ofs.valid;
    end
    s1_addr_r   <= ofs.addr;
    s1_center_r <= ofs.d2 == 8'd0;
    s1_g_r      <= g_nxt;
    if (accept && in_ch.action == ACT_READ) begin
      rd_inside_r <= in_image;
    end
  end

  always_comb begin
    glow_wdata = '0;
    rd_data    = '0;
    s1_rr      = '0;
    sum        = '0;
    for (int k = 0; k < 3; k++) begin
      sum = 14'(glow_q_r[8*k +: 8]) + 14'(s1_g_r[k]);
      s1_rr = (sum > 14'd255) ? 8'd255 : sum[7:0];
      glow_wdata[8*k +: 8] = s1_center_r ? 8'd255 : s1_rr;
      sum = 14'(glow_q_r[8*k +: 8]) + 14'(frame_q_r[8*k +: 8]);
      rd_data[8*k +: 8] = !rd_inside_r ? 8'd0 : ((sum > 14'd255) ? 8'd255 : sum[7:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= rd_data;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_data_r[7:0];
  assign out_ch.green_out = out_data_r[15:8];
  assign out_ch.blue_out  = out_data_r[23:16];

  `IBS_ASSERT_NEVER(a_clr_no_scatter_write, state_r == ST_CLR && s1_valid_r)
  `IBS_ASSERT_IMPLY(a_ofs_only_in_scatter, ofs.issue, state_r == ST_SCAT)
  `IBS_ASSERT_NEXT(a_last_then_drain, ofs.last, state_r == ST_DRAIN)
  `IBS_ASSERT_IMPLY(a_ready_no_pending, in_ch.ready, !s1_valid_r && !ofs.issue)
endmodule

/* hdl/ibs_offset_gen.sv */
// Walks the scatter kernel offsets and yields target addresses and distances.
`timescale 1ns / 1ps
module ibs_offset_gen
  import ibs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] col,
  input  logic [7:0] row,
  input  logic [3:0] radius,
  input  logic [8:0] width,
  input  logic [8:0] height,
  output ofs_t       ofs
);
  logic              active_r, active_nxt;
  logic signed [5:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [7:0]        col_r, row_r;
  logic signed [5:0] r_s, r_last;
  logic signed [9:0] tx, ty;
  logic [11:0]       d2_full;
  logic [7:0]        rr;
  logic              at_dx_end, at_dy_end;

  always_comb begin
    r_s       = $signed({2'b00, radius});
    r_last    = r_s - 6'sd1;
    tx        = $signed({2'b00, col_r}) + {{4{dx_r[5]}}, dx_r};
    ty        = $signed({2'b00, row_r}) + {{4{dy_r[5]}}, dy_r};
    d2_full   = 12'($signed(dx_r) * $signed(dx_r)) + 12'($signed(dy_r) * $signed(dy_r));
    rr        = 8'(radius * radius);
    at_dx_end = dx_r == r_last;
    at_dy_end = dy_r == r_last;
    ofs.issue = active_r;
    ofs.last  = active_r && at_dx_end && at_dy_end;
    ofs.valid = active_r && !tx[9] && !ty[9]
                && (tx < $signed({1'b0, width})) && (ty < $signed({1'b0, height}))
                && (d2_full[7:0] <= rr);
    ofs.addr  = {ty[7:0], tx[7:0]};
    ofs.d2    = d2_full[7:0];
    active_nxt = active_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    if (start) begin
      active_nxt = 1'b1;
      dx_nxt     = -r_s;
      dy_nxt     = -r_s;
    end else if (active_r) begin
      if (at_dx_end) begin
        dx_nxt = -r_s;
        dy_nxt = dy_r + 6'sd1;
        if (at_dy_end) begin
          active_nxt = 1'b0;
        end
      end else begin
        dx_nxt = dx_r + 6'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    if (start) begin
      col_r <= col;
      row_r <= row;
    end
  end
endmodule

/* sim/ibs_bloom_checker.sv */
// Checker for the bloom engine: predicts each read result and compares it with the output channel.
`timescale 1ns / 1ps
module ibs_bloom_checker
  import ibs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata,
  ibs_in_if           in_ch,
  ibs_out_if          out_ch,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  rgb_t        frame_mem [MAX_WIDTH*MAX_HEIGHT];
  rgb_t        glow_mem [MAX_WIDTH*MAX_HEIGHT];
  longint      inv_dist [RCP_DEPTH];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [9:0]  thr_reg;
  logic [11:0] gain_reg;
  logic [3:0]  radius_reg;
  rgb_t        expected_pixels [$];

  initial begin
    longint n;
    fail_count = 0;
    pending = 0;
    inv_dist[0] = 0;
    for (int d = 1; d < RCP_DEPTH; d++) begin
      n = 0;
      while ((2 * (n + 1) - 1) * (2 * (n + 1) - 1) * d <= (64'd1 << 32)) begin
        n++;
      end
      inv_dist[d] = n;
    end
  end

  function automatic logic [7:0] sat8(longint a, longint b);
    longint s;
    s = a + b;
    return (s > 255) ? 8'hff : s[7:0];
  endfunction

  function automatic logic [7:0] glow_add(logic [7:0] cur, logic [7:0] src, int d2);
    if (d2 == 0) begin
      return 8'hff;
    end
    return sat8(cur, (longint'(src) * longint'(gain_reg) * inv_dist[d2]) >>> 23);
  endfunction

  task automatic report(string msg);
    $display("%s at %0t", msg, $realtime);
    fail_count++;
  endtask

  task automatic spread_glow(int col, int row, int w, int h, rgb_t src);
    int   rad;
    int   tx;
    int   ty;
    int   d2;
    rgb_t e;
    rad = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    for (int dy = -rad; dy < rad; dy++) begin
      for (int dx = -rad; dx < rad; dx++) begin
        tx = col + dx;
        ty = row + dy;
        d2 = dx * dx + dy * dy;
        if (tx >= 0 && tx < w && ty >= 0 && ty < h && d2 <= rad * rad) begin
          e = glow_mem[ty * MAX_WIDTH + tx];
          e.r = glow_add(e.r, src.r, d2);
          e.g = glow_add(e.g, src.g, d2);
          e.b = glow_add(e.b, src.b, d2);
          glow_mem[ty * MAX_WIDTH + tx] = e;
        end
      end
    end
  endtask

  task automatic apply_item();
    int   w;
    int   h;
    int   addr;
    bit   in_image;
    rgb_t px;
    rgb_t res;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    in_image = in_ch.column < w && in_ch.row < h;
    addr = in_ch.row * MAX_WIDTH + in_ch.column;
    px = '{in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    case (in_ch.action)
      ACT_WRITE: begin
        if (in_image) begin
          frame_mem[addr] = px;
          if (px.r + px.g + px.b > thr_reg) begin
            spread_glow(in_ch.column, in_ch.row, w, h, px);
          end
        end
      end
      ACT_READ: begin
        res = '0;
        if (in_image) begin
          res.r = sat8(frame_mem[addr].r, glow_mem[addr].r);
          res.g = sat8(frame_mem[addr].g, glow_mem[addr].g);
          res.b = sat8(frame_mem[addr].b, glow_mem[addr].b);
        end
        expected_pixels.push_back(res);
      end
      ACT_CLEAR: begin
        foreach (glow_mem[i]) glow_mem[i] = '0;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      width_reg = 9'd256;
      height_reg = 9'd256;
      thr_reg = 10'd383;
      gain_reg = 12'd256;
      radius_reg = 4'd4;
      foreach (glow_mem[i]) glow_mem[i] = '0;
      expected_pixels.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected result transfer");
        end else begin
          want = expected_pixels.pop_front();
          if (out_ch.red_out !== want.r) begin
            report($sformatf("mismatch on red: got %0d, expected %0d",
                             out_ch.red_out, want.r));
          end
          if (out_ch.green_out !== want.g) begin
            report($sformatf("mismatch on green: got %0d, expected %0d",
                             out_ch.green_out, want.g));
          end
          if (out_ch.blue_out !== want.b) begin
            report($sformatf("mismatch on blue: got %0d, expected %0d",
                             out_ch.blue_out, want.b));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_item();
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:     width_reg = cfg_wdata[8:0];
          REG_HEIGHT:    height_reg = cfg_wdata[8:0];
          REG_THRESHOLD: thr_reg = cfg_wdata[9:0];
          REG_INTENSITY: gain_reg = cfg_wdata[11:0];
          REG_RADIUS:    radius_reg = cfg_wdata[3:0];
          default: begin
          end
        endcase
      end
    end
    pending = expected_pixels.size();
  end
endmodule

/* sim/tb_image_bloom_scatter.sv */
// Testbench top of the bloom engine: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_image_bloom_scatter;
  import ibs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [11:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          cycles;
  int          idle_mode;
  int          hold_left;
  int          img_w;
  int          img_h;
  bit          written_map [MAX_WIDTH*MAX_HEIGHT];
  int          written_addrs [$];

  ibs_in_if  in_ch ();
  ibs_out_if out_ch ();

  image_bloom_scatter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ibs_bloom_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (idle_mode == 2) begin
      out_ch.ready <= ($urandom_range(99) >= 46);
    end else if (idle_mode == 3) begin
      out_ch.ready <= ($urandom_range(99) >= 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(logic [1:0] act, int col, int row, int r, int g, int b);
    int addr;
    while ((idle_mode == 1 && $urandom_range(99) < 46) ||
           (idle_mode == 3 && $urandom_range(99) < 6)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.column <= col[7:0];
    in_ch.row <= row[7:0];
    in_ch.red_in <= r[7:0];
    in_ch.green_in <= g[7:0];
    in_ch.blue_in <= b[7:0];
    do @(posedge clk); while (!in_ch.ready);
    addr = row * MAX_WIDTH + col;
    if (act == ACT_WRITE && col < img_w && row < img_h && !written_map[addr]) begin
      written_map[addr] = 1'b1;
      written_addrs.push_back(addr);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[11:0];
    @(negedge clk);
  endtask

  task automatic settle();
    send(ACT_READ, 255, 255, 0, 0, 0);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(int w, int h, int thr, int gain, int rad);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_INTENSITY, gain);
    write_reg(REG_RADIUS, rad);
    cfg_we <= 1'b0;
    @(negedge clk);
    img_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    img_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  task automatic random_items(int count);
    int p;
    int col;
    int row;
    int r;
    int g;
    int b;
    int addr;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(99);
      col = $urandom_range(255);
      row = $urandom_range(255);
      if (p < 1) begin
        send(ACT_CLEAR, col, row, $urandom_range(255), 0, 0);
      end else if (p < 4) begin
        send(ACT_UNUSED, col, row, $urandom_range(255), 0, 0);
      end else if (p < 50 || written_addrs.size() == 0) begin
        if (img_w > 0 && img_h > 0 && $urandom_range(9) != 0) begin
          col = $urandom_range(img_w - 1);
          row = $urandom_range(img_h - 1);
        end
        if ($urandom_range(2) == 0) begin
          r = $urandom_range(255, 200);
          g = $urandom_range(255, 200);
          b = $urandom_range(255, 200);
        end else begin
          r = $urandom_range(255);
          g = $urandom_range(255);
          b = $urandom_range(255);
        end
        send(ACT_WRITE, col, row, r, g, b);
      end else begin
        addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
        if ($urandom_range(9) < 7) begin
          col = addr % MAX_WIDTH;
          row = addr / MAX_WIDTH;
        end else if (col < img_w && row < img_h && !written_map[row * MAX_WIDTH + col]) begin
          col = addr % MAX_WIDTH;
          row = addr / MAX_WIDTH;
        end
        send(ACT_READ, col, row, $urandom_range(255), $urandom_range(255), 0);
      end
    end
    settle();
  endtask

  initial begin
    cycles = 0;
    idle_mode = 0;
    hold_left = 0;
    img_w = MAX_WIDTH;
    img_h = MAX_HEIGHT;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.column = '0;
    in_ch.row = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(ACT_WRITE, 255, 255, 255, 255, 255);
    send(ACT_WRITE, 0, 0, 255, 255, 255);
    send(ACT_WRITE, 255, 0, 0, 0, 0);
    send(ACT_WRITE, 0, 255, 128, 128, 127);
    send(ACT_WRITE, 10, 10, 128, 128, 128);
    send(ACT_WRITE, 12, 10, 1, 2, 3);
    send(ACT_READ, 0, 0, 0, 0, 0);
    send(ACT_READ, 255, 255, 0, 0, 0);
    send(ACT_READ, 255, 0, 0, 0, 0);
    send(ACT_READ, 0, 255, 0, 0, 0);
    send(ACT_READ, 10, 10, 0, 0, 0);
    send(ACT_READ, 12, 10, 0, 0, 0);
    send(ACT_UNUSED, 5, 5, 255, 255, 255);
    send(ACT_CLEAR, 0, 0, 0, 0, 0);
    send(ACT_READ, 10, 10, 0, 0, 0);
    settle();

    configure(16, 16, 300, 256, 4);
    send(ACT_WRITE, 20, 3, 255, 255, 255);
    send(ACT_READ, 200, 100, 0, 0, 0);
    send(ACT_WRITE, 14, 14, 1, 2, 3);
    send(ACT_WRITE, 15, 15, 255, 255, 255);
    send(ACT_READ, 14, 14, 0, 0, 0);
    random_items(50);

    idle_mode = 1;
    configure(1, 1, 0, 4095, 8);
    random_items(30);

    idle_mode = 2;
    configure(20, 12, 1023, 100, 3);
    random_items(40);

    idle_mode = 3;
    configure(256, 256, 0, 0, 0);
    random_items(50);

    idle_mode = 4;
    configure(17, 9, 200, 4095, 8);
    @(posedge clk);
    hold_left = 3000;
    @(negedge clk);
    for (int i = 0; i < 40; i++) begin
      send(ACT_READ, 255, 255, 0, 0, 0);
    end
    random_items(40);

    idle_mode = 0;
    configure(30, 30, 400, 1000, 15);
    random_items(50);

    idle_mode = 3;
    configure(511, 300, 765, 2048, 1);
    random_items(50);

    idle_mode = 1;
    configure(0, 5, 100, 300, 2);
    random_items(20);

    idle_mode = 2;
    configure(24, 24, 350, 512, 6);
    random_items(50);

    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
